// ----- hdl/waypoint_velocity_controller_assert.svh -----
// assertion macros for the waypoint velocity controller
// each check is sampled at the rising edge of clk and is disabled while rst_n is low
`ifndef WAYPOINT_VELOCITY_CONTROLLER_ASSERT_SVH
`define WAYPOINT_VELOCITY_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define WVC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wvc assertion failed");
`define WVC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wvc assertion failed");
`else
`define WVC_ASSERT(lbl, ante, cons)
`define WVC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/wvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_pkg
// shared types, constants and the arctangent table of the velocity controller
// ----------------------------------------------------------------------------
package wvc_pkg;

  localparam int MAP_SIZE     = 1024;
  localparam int MAX_PATH     = 4096;
  localparam int LEN_W        = 13;
  localparam int CELL_W       = 10;
  localparam int POS_W        = 20;
  localparam int HD_W         = 16;
  localparam int CS_W         = 16;
  localparam int LIN_W        = 15;
  localparam int ANG_W        = 16;
  localparam int CFG_DW       = 16;
  localparam int CFG_IW       = 1;

  localparam int MUL_W        = 16;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DIFF_W       = 28;
  localparam int CORD_W       = 32;
  localparam int ANGLE_W      = 21;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int DIV_NW       = 45;
  localparam int DIV_DW       = 30;
  localparam int DIV_QW       = 17;

  localparam logic [CFG_IW-1:0] CFG_CELL_SIZE = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_LOOKAHEAD = 1'd1;

  localparam logic signed [ANGLE_W-1:0] ANG_PI      = 21'sd205887;
  localparam logic signed [ANGLE_W-1:0] ANG_TWO_PI  = 21'sd411774;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 21'sd102944;
  localparam logic signed [ANGLE_W-1:0] ANG_LIMIT   = 21'sd19661;
  localparam logic signed [CORD_W-1:0]  CORDIC_K30  = 32'sd652032875;

  localparam logic [DIV_DW-1:0] V_DEN      = 30'd29327360;
  localparam logic [DIV_DW-1:0] W_DEN      = 30'd573603840;
  localparam logic [DIV_NW-1:0] V_HALF     = 45'd14663680;
  localparam logic [DIV_NW-1:0] W_HALF     = 45'd286801920;
  localparam logic [DIFF_W-1:0] NEAR_LIMIT = 28'd19661;
  localparam logic [35:0]       DIST_LIMIT = 36'd9663676416;

  typedef struct packed {
    logic [LEN_W-1:0]         path_len;
    logic [CELL_W-1:0]        wp_row;
    logic [CELL_W-1:0]        wp_col;
    logic signed [POS_W-1:0]  robot_x;
    logic signed [POS_W-1:0]  robot_y;
    logic signed [HD_W-1:0]   robot_heading;
  } in_word_t;

  typedef struct packed {
    logic [LIN_W-1:0]         lin_vel;
    logic signed [ANG_W-1:0]  ang_vel;
    logic                     goal_reached;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic                       start;
    logic                       vec;
    logic signed [CORD_W-1:0]   x0;
    logic signed [CORD_W-1:0]   y0;
    logic signed [ANGLE_W-1:0]  z0;
  } cord_req_t;

  // atan(2^-i) in 2^-16 rad
  function automatic logic signed [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] r;
    case (idx)
      4'd0:    r = 21'sd51472;
      4'd1:    r = 21'sd30385;
      4'd2:    r = 21'sd16055;
      4'd3:    r = 21'sd8150;
      4'd4:    r = 21'sd4091;
      4'd5:    r = 21'sd2047;
      4'd6:    r = 21'sd1024;
      4'd7:    r = 21'sd512;
      4'd8:    r = 21'sd256;
      4'd9:    r = 21'sd128;
      4'd10:   r = 21'sd64;
      4'd11:   r = 21'sd32;
      4'd12:   r = 21'sd16;
      4'd13:   r = 21'sd8;
      4'd14:   r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/wvc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module wvc_mul (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire wvc_pkg::mul_req_t          req,
  output logic [wvc_pkg::PROD_W-1:0]      p,
  output logic                            done
);

  logic [wvc_pkg::MUL_W-1:0]  a_r;
  logic [wvc_pkg::PROD_W-1:0] p_r;
  logic [wvc_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [wvc_pkg::MUL_W:0]    hi_sum;

  // add the multiplicand into the upper half, then shift the whole word right
  assign hi_sum = {1'b0, p_r[wvc_pkg::PROD_W-1:wvc_pkg::MUL_W]} +
                  (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wvc_pkg::STEP_W'(wvc_pkg::MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      p_r <= {{wvc_pkg::MUL_W{1'b0}}, req.b};
    end else if (busy_r) begin
      p_r <= {hi_sum, p_r[wvc_pkg::MUL_W-1:1]};
    end
  end

  assign p    = p_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ----- hdl/wvc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wvc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire wvc_pkg::div_req_t          req,
  output logic [wvc_pkg::DIV_QW-1:0]      q,
  output logic                            done
);

  logic [wvc_pkg::DIV_DW-1:0] d_r;
  logic [wvc_pkg::DIV_DW-1:0] rem_r;
  logic [wvc_pkg::DIV_QW-1:0] qsh_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [wvc_pkg::DIV_DW:0]   trial;
  logic [wvc_pkg::DIV_DW:0]   diff;
  logic                       fits;

  // the caller must keep the upper dividend bits below the divisor; the divider does not check it
  assign trial = {rem_r, qsh_r[wvc_pkg::DIV_QW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'(wvc_pkg::DIV_QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      d_r   <= req.d;
      rem_r <= wvc_pkg::DIV_DW'(req.n[wvc_pkg::DIV_NW-1:wvc_pkg::DIV_QW]);
      qsh_r <= req.n[wvc_pkg::DIV_QW-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? diff[wvc_pkg::DIV_DW-1:0] : trial[wvc_pkg::DIV_DW-1:0];
      qsh_r <= {qsh_r[wvc_pkg::DIV_QW-2:0], fits};
    end
  end

  assign q    = qsh_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ----- hdl/wvc_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_cordic
// shared cordic, one micro-rotation per cycle, vectoring or rotation mode
// ----------------------------------------------------------------------------
module wvc_cordic (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wvc_pkg::cord_req_t              req,
  output logic signed [wvc_pkg::CORD_W-1:0]    x,
  output logic signed [wvc_pkg::CORD_W-1:0]    y,
  output logic signed [wvc_pkg::ANGLE_W-1:0]   z,
  output logic                                 done
);

  logic signed [wvc_pkg::CORD_W-1:0]  x_r;
  logic signed [wvc_pkg::CORD_W-1:0]  y_r;
  logic signed [wvc_pkg::ANGLE_W-1:0] z_r;
  logic                               vec_r;
  logic [wvc_pkg::STEP_W-1:0]         cnt_r;
  logic                               busy_r;
  logic                               done_r;
  logic signed [wvc_pkg::CORD_W-1:0]  xs;
  logic signed [wvc_pkg::CORD_W-1:0]  ys;
  logic signed [wvc_pkg::ANGLE_W-1:0] t;
  logic                               u;

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign t  = wvc_pkg::atan_lut(cnt_r);
  // vectoring drives y to zero, rotation drives z to zero
  assign u  = vec_r ? y_r[wvc_pkg::CORD_W-1] : !z_r[wvc_pkg::ANGLE_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wvc_pkg::STEP_W'(wvc_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x0;
      y_r   <= req.y0;
      z_r   <= req.z0;
      vec_r <= req.vec;
    end else if (busy_r) begin
      x_r <= u ? x_r - ys : x_r + ys;
      y_r <= u ? y_r + xs : y_r - xs;
      z_r <= u ? z_r - t  : z_r + t;
    end
  end

  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ----- hdl/waypoint_velocity_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "waypoint_velocity_controller_assert.svh"
// ----------------------------------------------------------------------------
// waypoint_velocity_controller
// steers toward one path waypoint with damped linear and angular velocity
// ----------------------------------------------------------------------------
// usage
//   in_*  : one word per control tick: path length, waypoint cell, robot pose
//   out_* : one word per input word: lin_vel, ang_vel, goal_reached
//   cfg_* : cell_size (index 0) and lookahead_cells (index 1), to be written
//           only when idle; the block itself does not enforce it
// sequence, from the accepting edge to out_valid: the serial units run in turn,
//   two shift-add multiplies for the waypoint position, two more for the
//   distance check, two 16-step cordic passes, two 17-step divides; an empty
//   path stops after the waypoint multiplies, a goal stop after the distance
//   check, and the distance check runs only on the last waypoint with both
//   offsets under 0.3 m
// input: one word at a time; the next word is taken only in idle, after the
//   previous result has been loaded into the output register
// reset: velocity history cleared, cell_size 3277, lookahead_cells 20
// receiver stall: the result is held in the output register; a finished
//   result that cannot be loaded waits in its own state until out_ready
// ----------------------------------------------------------------------------
module waypoint_velocity_controller (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire wvc_pkg::in_word_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output wvc_pkg::out_word_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [wvc_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [wvc_pkg::CFG_DW-1:0]  cfg_wdata
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_MUL_R  = 15'b000000000000010,
    ST_MUL_C  = 15'b000000000000100,
    ST_DECIDE = 15'b000000000001000,
    ST_SQ_X   = 15'b000000000010000,
    ST_SQ_Y   = 15'b000000000100000,
    ST_VEC    = 15'b000000001000000,
    ST_WRAP   = 15'b000000010000000,
    ST_ROT    = 15'b000000100000000,
    ST_NUMS   = 15'b000001000000000,
    ST_LAUNCH = 15'b000010000000000,
    ST_DIV_V  = 15'b000100000000000,
    ST_DIV_W  = 15'b001000000000000,
    ST_OUT    = 15'b010000000000000,
    ST_SPARE  = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [wvc_pkg::CS_W-1:0]   cs_r;
  logic [wvc_pkg::LEN_W-1:0]  look_r;

  // held word and working registers
  wvc_pkg::in_word_t                 in_r;
  logic [25:0]                       rowp_r;
  logic signed [wvc_pkg::DIFF_W-1:0] dx_r;
  logic signed [wvc_pkg::DIFF_W-1:0] dy_r;
  logic [wvc_pkg::PROD_W-1:0]        sqx_r;
  logic signed [wvc_pkg::ANGLE_W-1:0] a_r;
  logic                              fold_r;
  logic signed [wvc_pkg::CORD_W-1:0] c_r;
  logic signed [wvc_pkg::CORD_W-1:0] s_r;
  logic                              nv_neg_r;
  logic [wvc_pkg::DIV_NW-1:0]        nv_mag_r;
  logic                              nw_neg_r;
  logic [wvc_pkg::DIV_NW-1:0]        nw_mag_r;
  logic [wvc_pkg::DIV_QW-1:0]        qv_r;

  // velocity history and result
  logic [wvc_pkg::LIN_W-1:0]         prev_lin_r;
  logic signed [wvc_pkg::ANG_W-1:0]  prev_ang_r;
  wvc_pkg::out_word_t                res_r;
  wvc_pkg::out_word_t                res_val;
  logic                              res_load;
  logic                              out_valid_r;
  wvc_pkg::out_word_t                out_data_r;

  // serial units
  wvc_pkg::mul_req_t                  mul_req;
  logic [wvc_pkg::PROD_W-1:0]         mul_p;
  logic                               mul_done;
  wvc_pkg::div_req_t                  div_req;
  logic [wvc_pkg::DIV_QW-1:0]         div_q;
  logic                               div_done;
  wvc_pkg::cord_req_t                 cord_req;
  logic signed [wvc_pkg::CORD_W-1:0]  cord_x;
  logic signed [wvc_pkg::CORD_W-1:0]  cord_y;
  logic signed [wvc_pkg::ANGLE_W-1:0] cord_z;
  logic                               cord_done;

  wvc_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .p    (mul_p),
    .done (mul_done)
  );

  wvc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .q    (div_q),
    .done (div_done)
  );

  wvc_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cord_req),
    .x    (cord_x),
    .y    (cord_y),
    .z    (cord_z),
    .done (cord_done)
  );

  // ---------------------------------------------------------------------------
  // datapath terms
  // ---------------------------------------------------------------------------
  logic [wvc_pkg::LEN_W-1:0]          len_sat;
  logic                               len_zero;
  logic                               is_last;
  logic signed [wvc_pkg::DIFF_W-1:0]  rx64;
  logic signed [wvc_pkg::DIFF_W-1:0]  ry64;
  logic [wvc_pkg::DIFF_W-1:0]         dx_abs;
  logic [wvc_pkg::DIFF_W-1:0]         dy_abs;
  logic                               near;
  logic [35:0]                        sq_sum;
  logic [35:0]                        dist25;
  logic                               close;
  logic                               on_robot;
  wvc_pkg::cord_req_t                 vec_req;
  logic signed [wvc_pkg::ANGLE_W-1:0] bear;
  logic signed [wvc_pkg::ANGLE_W-1:0] hd8;
  logic signed [wvc_pkg::ANGLE_W-1:0] a_raw;
  logic signed [wvc_pkg::ANGLE_W-1:0] a_wrap;
  logic signed [wvc_pkg::ANGLE_W-1:0] rot_z0;
  logic                               rot_fold;
  logic signed [34:0]                 nv_base;
  logic signed [41:0]                 nv42;
  logic signed [41:0]                 nv100;
  logic signed [45:0]                 s46;
  logic signed [45:0]                 pa46;
  logic signed [45:0]                 nw;
  logic [45:0]                        nw_abs;
  logic [wvc_pkg::DIV_QW-1:0]         qn;
  logic [wvc_pkg::LIN_W-1:0]          v_fin;
  logic signed [wvc_pkg::ANG_W-1:0]   w_fin;
  logic                               a_big;

  assign len_sat  = (in_r.path_len > wvc_pkg::LEN_W'(wvc_pkg::MAX_PATH)) ?
                    wvc_pkg::LEN_W'(wvc_pkg::MAX_PATH) : in_r.path_len;
  assign len_zero = (len_sat == '0);
  assign is_last  = (len_sat <= look_r);

  // pose scaled from 1/1024 m to 1/65536 m
  assign rx64 = $signed({{2{in_r.robot_x[wvc_pkg::POS_W-1]}}, in_r.robot_x, 6'b000000});
  assign ry64 = $signed({{2{in_r.robot_y[wvc_pkg::POS_W-1]}}, in_r.robot_y, 6'b000000});

  assign dx_abs = dx_r[wvc_pkg::DIFF_W-1] ? wvc_pkg::DIFF_W'(-dx_r) : dx_r;
  assign dy_abs = dy_r[wvc_pkg::DIFF_W-1] ? wvc_pkg::DIFF_W'(-dy_r) : dy_r;
  // either offset at or beyond 0.3 m cannot be inside the goal circle
  assign near   = (dx_abs < wvc_pkg::NEAR_LIMIT) && (dy_abs < wvc_pkg::NEAR_LIMIT);

  assign sq_sum = 36'(sqx_r) + 36'(mul_p);
  assign dist25 = (sq_sum << 4) + (sq_sum << 3) + sq_sum;
  assign close  = dist25 < wvc_pkg::DIST_LIMIT;

  // bearing: fold the left half-plane onto the right one first
  assign on_robot = (dx_r == '0) && (dy_r == '0);
  always_comb begin
    vec_req.start = 1'b1;
    vec_req.vec   = 1'b1;
    if (dx_r[wvc_pkg::DIFF_W-1]) begin
      vec_req.x0 = -wvc_pkg::CORD_W'(dx_r);
      vec_req.y0 = -wvc_pkg::CORD_W'(dy_r);
      vec_req.z0 = dy_r[wvc_pkg::DIFF_W-1] ? -wvc_pkg::ANG_PI : wvc_pkg::ANG_PI;
    end else begin
      vec_req.x0 = wvc_pkg::CORD_W'(dx_r);
      vec_req.y0 = wvc_pkg::CORD_W'(dy_r);
      vec_req.z0 = '0;
    end
  end

  // bearing error against heading, wrapped once into [-pi, pi]
  assign bear   = on_robot ? '0 : cord_z;
  assign hd8    = $signed({{2{in_r.robot_heading[wvc_pkg::HD_W-1]}},
                           in_r.robot_heading, 3'b000});
  assign a_raw  = bear - hd8;
  assign a_wrap = (a_raw > wvc_pkg::ANG_PI)  ? a_raw - wvc_pkg::ANG_TWO_PI :
                  (a_raw < -wvc_pkg::ANG_PI) ? a_raw + wvc_pkg::ANG_TWO_PI : a_raw;

  // rotation input kept within +-pi/2, the result flipped back afterwards
  always_comb begin
    rot_fold = 1'b1;
    if (a_r > wvc_pkg::ANG_HALF_PI) begin
      rot_z0 = a_r - wvc_pkg::ANG_PI;
    end else if (a_r < -wvc_pkg::ANG_HALF_PI) begin
      rot_z0 = a_r + wvc_pkg::ANG_PI;
    end else begin
      rot_z0   = a_r;
      rot_fold = 1'b0;
    end
  end

  // numerators of the two damped updates
  assign nv_base = 35'(c_r) + $signed({2'b00, 18'(prev_lin_r * 3'd5), 15'b0});
  assign nv42    = 42'(nv_base);
  assign nv100   = (nv42 <<< 6) + (nv42 <<< 5) + (nv42 <<< 2);
  // 3895 = 4096 - 128 - 64 - 8 - 1, 10000 = 8192 + 1024 + 512 + 256 + 16
  assign s46     = 46'(s_r);
  assign pa46    = 46'(prev_ang_r);
  assign nw      = (s46 <<< 12) - (s46 <<< 7) - (s46 <<< 6) - (s46 <<< 3) - s46 +
                   (((pa46 <<< 13) + (pa46 <<< 10) + (pa46 <<< 9) + (pa46 <<< 8) +
                     (pa46 <<< 4)) <<< 15);
  assign nw_abs  = nw[45] ? 46'(-nw) : nw;

  // final saturation and dead band
  assign a_big = (a_r > wvc_pkg::ANG_LIMIT) || (a_r < -wvc_pkg::ANG_LIMIT);
  assign qn    = -div_q;
  always_comb begin
    if (nv_neg_r || a_big) begin
      v_fin = '0;
    end else if (qv_r > wvc_pkg::DIV_QW'(32767)) begin
      v_fin = 15'd32767;
    end else begin
      v_fin = qv_r[wvc_pkg::LIN_W-1:0];
    end
    if (div_q <= wvc_pkg::DIV_QW'(3)) begin
      w_fin = '0;
    end else if (!nw_neg_r) begin
      w_fin = (div_q > wvc_pkg::DIV_QW'(32767)) ? 16'sd32767 : $signed(div_q[15:0]);
    end else begin
      w_fin = (div_q > wvc_pkg::DIV_QW'(32768)) ? -16'sd32768 : $signed(qn[15:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    mul_req   = '0;
    div_req   = '0;
    cord_req  = '0;
    res_load  = 1'b0;
    res_val   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mul_req   = '{start: 1'b1, a: cs_r, b: wvc_pkg::MUL_W'(in_data.wp_row)};
          state_nxt = ST_MUL_R;
        end
      end
      ST_MUL_R: begin
        if (mul_done) begin
          mul_req   = '{start: 1'b1, a: cs_r, b: wvc_pkg::MUL_W'(in_r.wp_col)};
          state_nxt = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        if (mul_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (len_zero) begin
          res_load  = 1'b1;
          state_nxt = ST_OUT;
        end else if (is_last && near) begin
          mul_req   = '{start: 1'b1, a: dx_abs[wvc_pkg::MUL_W-1:0],
                        b: dx_abs[wvc_pkg::MUL_W-1:0]};
          state_nxt = ST_SQ_X;
        end else begin
          cord_req  = vec_req;
          state_nxt = ST_VEC;
        end
      end
      ST_SQ_X: begin
        if (mul_done) begin
          mul_req   = '{start: 1'b1, a: dy_abs[wvc_pkg::MUL_W-1:0],
                        b: dy_abs[wvc_pkg::MUL_W-1:0]};
          state_nxt = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        if (mul_done) begin
          if (close) begin
            res_load             = 1'b1;
            res_val.goal_reached = 1'b1;
            state_nxt            = ST_OUT;
          end else begin
            cord_req  = vec_req;
            state_nxt = ST_VEC;
          end
        end
      end
      ST_VEC: begin
        if (cord_done) begin
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cord_req  = '{start: 1'b1, vec: 1'b0, x0: wvc_pkg::CORDIC_K30, y0: '0, z0: rot_z0};
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (cord_done) begin
          state_nxt = ST_NUMS;
        end
      end
      ST_NUMS: begin
        state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        div_req   = '{start: 1'b1, n: nv_mag_r, d: wvc_pkg::V_DEN};
        state_nxt = ST_DIV_V;
      end
      ST_DIV_V: begin
        if (div_done) begin
          div_req   = '{start: 1'b1, n: nw_mag_r, d: wvc_pkg::W_DEN};
          state_nxt = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (div_done) begin
          res_load        = 1'b1;
          res_val.lin_vel = v_fin;
          res_val.ang_vel = w_fin;
          state_nxt       = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state, configuration and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cs_r        <= 16'd3277;
      look_r      <= 13'd20;
      prev_lin_r  <= '0;
      prev_ang_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          wvc_pkg::CFG_CELL_SIZE: cs_r   <= cfg_wdata;
          wvc_pkg::CFG_LOOKAHEAD: look_r <= cfg_wdata[wvc_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (res_load) begin
        prev_lin_r <= res_val.lin_vel;
        prev_ang_r <= res_val.ang_vel;
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (state_r == ST_MUL_R && mul_done) begin
      rowp_r <= mul_p[25:0];
    end
    if (state_r == ST_MUL_C && mul_done) begin
      dx_r <= $signed({2'b00, rowp_r}) - rx64;
      dy_r <= $signed({2'b00, mul_p[25:0]}) - ry64;
    end
    if (state_r == ST_SQ_X && mul_done) begin
      sqx_r <= mul_p;
    end
    if (state_r == ST_VEC && cord_done) begin
      a_r <= a_wrap;
    end
    if (state_r == ST_WRAP) begin
      fold_r <= rot_fold;
    end
    if (state_r == ST_ROT && cord_done) begin
      c_r <= fold_r ? -cord_x : cord_x;
      s_r <= fold_r ? -cord_y : cord_y;
    end
    if (state_r == ST_NUMS) begin
      nv_neg_r <= nv_base[34];
      nv_mag_r <= wvc_pkg::DIV_NW'($unsigned(nv100)) + wvc_pkg::V_HALF;
      nw_neg_r <= nw[45];
      nw_mag_r <= wvc_pkg::DIV_NW'(nw_abs) + wvc_pkg::W_HALF;
    end
    if (state_r == ST_DIV_V && div_done) begin
      qv_r <= div_q;
    end
    if (res_load) begin
      res_r <= res_val;
    end
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `WVC_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == ST_MUL_R)
  `WVC_ASSERT(a_goal_stops, out_valid && out_data.goal_reached,
              out_data.lin_vel == '0 && out_data.ang_vel == '0)
  `WVC_ASSERT(a_dead_band, out_valid,
              out_data.ang_vel == 16'sd0 || out_data.ang_vel > 16'sd3 ||
              out_data.ang_vel < -16'sd3)
  `WVC_ASSERT(a_mul_owner, mul_done,
              state_r == ST_MUL_R || state_r == ST_MUL_C ||
              state_r == ST_SQ_X || state_r == ST_SQ_Y)

endmodule
`default_nettype wire
